### hw/rtl/rectangle_union_area_sweep_top_assert.svh
// Assertion macros for the checker of the rectangle union sweep block.
`ifndef RECTANGLE_UNION_AREA_SWEEP_TOP_ASSERT_SVH
`define RECTANGLE_UNION_AREA_SWEEP_TOP_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define RUSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rusa checker: property failed after antecedent");

// The consequent must hold in the cycle after reset is seen.
`define RUSA_ASSERT_RESET(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("rusa checker: property failed after reset");

`endif

### hw/rtl/rusa_pkg.sv
package rusa_pkg;

  localparam int COUNT_W   = 16;
  localparam int AREA_W    = 26;
  localparam int X_IN_W    = 16;
  localparam int Y_IN_W    = 11;
  localparam int WIDTH_O_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};

  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_TOP,
    ST_ENTER_RD,
    ST_FIN_RD,
    ST_FINAL,
    ST_RD_LC,
    ST_RD_RC,
    ST_DONE
  } state_t;

  // Where a stack frame stands in the walk of its node.
  typedef enum logic [1:0] {
    PH_ENTER,
    PH_RIGHT,
    PH_FIN
  } phase_t;

  typedef struct packed {
    logic   load;
    logic   mul;
    logic   add;
    logic   push_root;
    logic   rd_self;
    logic   rd_lc;
    logic   rd_rc;
    logic   cnt_apply;
    logic   cnt_keep;
    logic   set_phase;
    phase_t phase;
    logic   push_left;
    logic   push_right;
    logic   take_wl;
    logic   write_node;
    logic   pop;
    logic   clr_write;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic   empty_iv;
    phase_t phase;
    logic   full_cover;
    logic   span_gt1;
    logic   lo_lt_mid;
    logic   hi_gt_mid;
    logic   cnt_nz;
    logic   last_frame;
    logic   clear_last;
    logic   out_busy;
  } dp_stat_t;

endpackage

### hw/rtl/rusa_event_if.sv
interface rusa_event_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [rusa_pkg::X_IN_W-1:0]     x_coord;
  logic [rusa_pkg::Y_IN_W-1:0]     y_low;
  logic [rusa_pkg::Y_IN_W-1:0]     y_high;
  logic                            restart;

  modport source (output valid, operation, x_coord, y_low, y_high, restart, input ready);
  modport sink (input valid, operation, x_coord, y_low, y_high, restart, output ready);
endinterface

### hw/rtl/rusa_result_if.sv
interface rusa_result_if;
  logic                             valid;
  logic                             ready;
  logic [rusa_pkg::AREA_W-1:0]      area_so_far;
  logic [rusa_pkg::WIDTH_O_W-1:0]   covered_width;

  modport source (output valid, area_so_far, covered_width, input ready);
  modport sink (input valid, area_so_far, covered_width, output ready);
endinterface

### hw/rtl/rusa_ram.sv
module rusa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rusa_ctrl.sv
module rusa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rusa_pkg::dp_stat_t stat,
  output rusa_pkg::dp_cmd_t  cmd
);

  rusa_pkg::state_t state;
  rusa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rusa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      rusa_pkg::ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clear_last) begin
          state_next = rusa_pkg::ST_IDLE;
        end
      end
      rusa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rusa_pkg::ST_MUL;
        end
      end
      rusa_pkg::ST_MUL: begin
        if (stat.empty_iv) begin
          state_next = rusa_pkg::ST_DONE;
        end else begin
          cmd.mul    = 1'b1;
          state_next = rusa_pkg::ST_ADD;
        end
      end
      rusa_pkg::ST_ADD: begin
        cmd.add       = 1'b1;
        cmd.push_root = 1'b1;
        state_next    = rusa_pkg::ST_TOP;
      end
      rusa_pkg::ST_TOP: begin
        case (stat.phase)
          rusa_pkg::PH_ENTER: begin
            cmd.rd_self = 1'b1;
            state_next  = rusa_pkg::ST_ENTER_RD;
          end
          rusa_pkg::PH_RIGHT: begin
            cmd.set_phase  = 1'b1;
            cmd.phase      = rusa_pkg::PH_FIN;
            cmd.push_right = stat.hi_gt_mid;
          end
          default: begin
            cmd.rd_self = 1'b1;
            state_next  = rusa_pkg::ST_FIN_RD;
          end
        endcase
      end
      rusa_pkg::ST_ENTER_RD: begin
        if (stat.full_cover) begin
          cmd.cnt_apply = 1'b1;
          state_next    = rusa_pkg::ST_FINAL;
        end else if (stat.span_gt1) begin
          cmd.set_phase = 1'b1;
          cmd.phase     = rusa_pkg::PH_RIGHT;
          cmd.push_left = stat.lo_lt_mid;
          state_next    = rusa_pkg::ST_TOP;
        end else begin
          cmd.cnt_keep = 1'b1;
          state_next   = rusa_pkg::ST_FINAL;
        end
      end
      rusa_pkg::ST_FIN_RD: begin
        cmd.cnt_keep = 1'b1;
        state_next   = rusa_pkg::ST_FINAL;
      end
      rusa_pkg::ST_FINAL: begin
        if (stat.cnt_nz || !stat.span_gt1) begin
          cmd.write_node = 1'b1;
          cmd.pop        = 1'b1;
          state_next     = stat.last_frame ? rusa_pkg::ST_DONE : rusa_pkg::ST_TOP;
        end else begin
          cmd.rd_lc  = 1'b1;
          state_next = rusa_pkg::ST_RD_LC;
        end
      end
      rusa_pkg::ST_RD_LC: begin
        cmd.take_wl = 1'b1;
        cmd.rd_rc   = 1'b1;
        state_next  = rusa_pkg::ST_RD_RC;
      end
      rusa_pkg::ST_RD_RC: begin
        cmd.write_node = 1'b1;
        cmd.pop        = 1'b1;
        state_next     = stat.last_frame ? rusa_pkg::ST_DONE : rusa_pkg::ST_TOP;
      end
      rusa_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = rusa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rusa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/rusa_dp.sv
module rusa_dp #(
  parameter int Y_CELLS = 1024,
  parameter int X_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rusa_pkg::dp_cmd_t                cmd,
  output rusa_pkg::dp_stat_t               stat,
  input  logic                             operation,
  input  logic [rusa_pkg::X_IN_W-1:0]      x_coord,
  input  logic [rusa_pkg::Y_IN_W-1:0]      y_low,
  input  logic [rusa_pkg::Y_IN_W-1:0]      y_high,
  input  logic                             restart,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [rusa_pkg::AREA_W-1:0]      area_so_far,
  output logic [rusa_pkg::WIDTH_O_W-1:0]   covered_width
);

  localparam int NODES = 4 * Y_CELLS;
  localparam int AW    = $clog2(NODES);
  localparam int CW    = $clog2(Y_CELLS + 1);
  localparam int XW    = (X_BITS < rusa_pkg::X_IN_W) ? X_BITS : rusa_pkg::X_IN_W;
  localparam int SD    = $clog2(Y_CELLS) + 1;
  localparam int SPW   = $clog2(SD + 1);
  localparam int TW    = $clog2(SD);
  localparam int MW    = rusa_pkg::COUNT_W + CW;
  localparam int PW    = XW + CW;
  localparam int SW    = ((PW > rusa_pkg::AREA_W) ? PW : rusa_pkg::AREA_W) + 1;

  // Latched event.
  logic          op;
  logic [XW-1:0] x;
  logic [CW-1:0] ylo;
  logic [CW-1:0] yhi;

  logic [XW-1:0]                 prev_x;
  logic [rusa_pkg::AREA_W-1:0]   area;
  logic [PW-1:0]                 strip;
  logic [CW-1:0]                 root_width;
  logic [rusa_pkg::COUNT_W-1:0]  cnt;
  logic [CW-1:0]                 wl;
  logic [AW-1:0]                 clr_cnt;

  // Traversal stack, one frame per tree level.
  logic [SPW-1:0]         sp;
  logic [AW-1:0]          stk_idx [SD];
  logic [CW-1:0]          stk_b   [SD];
  logic [CW-1:0]          stk_e   [SD];
  rusa_pkg::phase_t       stk_ph  [SD];

  logic [SPW-1:0]         sp_m1;
  logic [TW-1:0]          top;
  logic [TW-1:0]          nxt;
  logic [AW-1:0]          t_idx;
  logic [CW-1:0]          t_b;
  logic [CW-1:0]          t_e;
  logic [CW-1:0]          span;
  logic [CW-1:0]          mid;
  logic [AW-1:0]          lc;
  logic [AW-1:0]          rc;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [MW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [MW-1:0]          ram_rdata;
  logic [rusa_pkg::COUNT_W-1:0] rd_cnt;
  logic [CW-1:0]          rd_w;
  logic [rusa_pkg::COUNT_W-1:0] cnt_upd;
  logic [CW-1:0]          new_w;

  logic [31:0]            ylo32;
  logic [31:0]            yhi32;
  logic [CW-1:0]          ylo_sat;
  logic [CW-1:0]          yhi_sat;
  logic [XW-1:0]          delta;
  logic [PW-1:0]          prod;
  logic [SW-1:0]          sum;
  logic [31:0]            rw32;

  assign sp_m1 = sp - 1'b1;
  assign top   = sp_m1[TW-1:0];
  assign nxt   = sp[TW-1:0];
  assign t_idx = stk_idx[top];
  assign t_b   = stk_b[top];
  assign t_e   = stk_e[top];
  assign span  = t_e - t_b;
  assign mid   = t_b + (span >> 1);
  assign lc    = (t_idx << 1) + AW'(1);
  assign rc    = (t_idx << 1) + AW'(2);

  assign ylo32   = 32'(y_low);
  assign yhi32   = 32'(y_high);
  assign ylo_sat = (ylo32 > 32'(Y_CELLS)) ? CW'(Y_CELLS) : CW'(y_low);
  assign yhi_sat = (yhi32 > 32'(Y_CELLS)) ? CW'(Y_CELLS) : CW'(y_high);

  assign delta = (x > prev_x) ? (x - prev_x) : '0;
  assign prod  = PW'(delta) * PW'(root_width);
  assign sum   = SW'(area) + SW'(strip);
  assign rw32  = 32'(root_width);

  assign rd_cnt = ram_rdata[MW-1:CW];
  assign rd_w   = ram_rdata[CW-1:0];

  always_comb begin
    cnt_upd = rd_cnt;
    if (op == rusa_pkg::OP_OPEN) begin
      if (rd_cnt != rusa_pkg::COUNT_MAX) begin
        cnt_upd = rd_cnt + 1'b1;
      end
    end else if (rd_cnt != '0) begin
      cnt_upd = rd_cnt - 1'b1;
    end
  end

  // A node still covered whole spans its full width; otherwise its children add up, and an uncovered leaf is zero.
  always_comb begin
    if (cnt != '0) begin
      new_w = span;
    end else if (span > CW'(1)) begin
      new_w = wl + rd_w;
    end else begin
      new_w = '0;
    end
  end

  assign ram_we    = cmd.write_node | cmd.clr_write;
  assign ram_waddr = cmd.clr_write ? clr_cnt : t_idx;
  assign ram_wdata = cmd.clr_write ? '0 : {cnt, new_w};
  assign ram_raddr = cmd.rd_lc ? lc : (cmd.rd_rc ? rc : t_idx);

  rusa_ram #(
    .WIDTH (MW),
    .DEPTH (NODES)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= operation;
      x   <= x_coord[XW-1:0];
      ylo <= ylo_sat;
      yhi <= yhi_sat;
    end
    if (cmd.mul) begin
      strip <= prod;
    end
    if (cmd.cnt_apply) begin
      cnt <= cnt_upd;
    end else if (cmd.cnt_keep) begin
      cnt <= rd_cnt;
    end
    if (cmd.take_wl) begin
      wl <= rd_w;
    end
    if (cmd.out_load) begin
      area_so_far   <= area;
      covered_width <= rw32[rusa_pkg::WIDTH_O_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x     <= '0;
      area       <= '0;
      root_width <= '0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load && restart) begin
        prev_x <= '0;
        area   <= '0;
      end
      if (cmd.add) begin
        prev_x <= x;
        area   <= (sum > SW'(rusa_pkg::AREA_MAX)) ? rusa_pkg::AREA_MAX
                                                  : sum[rusa_pkg::AREA_W-1:0];
      end
      if (cmd.write_node && t_idx == '0) begin
        root_width <= new_w;
      end
      if (cmd.clr_write) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.push_root) begin
      sp <= SPW'(1);
    end else if (cmd.push_left || cmd.push_right) begin
      sp <= sp + 1'b1;
    end else if (cmd.pop) begin
      sp <= sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_root) begin
      stk_idx[0] <= '0;
      stk_b[0]   <= '0;
      stk_e[0]   <= CW'(Y_CELLS);
      stk_ph[0]  <= rusa_pkg::PH_ENTER;
    end
    if (cmd.set_phase) begin
      stk_ph[top] <= cmd.phase;
    end
    if (cmd.push_left) begin
      stk_idx[nxt] <= lc;
      stk_b[nxt]   <= t_b;
      stk_e[nxt]   <= mid;
      stk_ph[nxt]  <= rusa_pkg::PH_ENTER;
    end
    if (cmd.push_right) begin
      stk_idx[nxt] <= rc;
      stk_b[nxt]   <= mid;
      stk_e[nxt]   <= t_e;
      stk_ph[nxt]  <= rusa_pkg::PH_ENTER;
    end
  end

  always_comb begin
    stat.empty_iv   = !(ylo < yhi);
    stat.phase      = stk_ph[top];
    stat.full_cover = (ylo <= t_b) && (t_e <= yhi);
    stat.span_gt1   = span > CW'(1);
    stat.lo_lt_mid  = ylo < mid;
    stat.hi_gt_mid  = yhi > mid;
    stat.cnt_nz     = cnt != '0;
    stat.last_frame = sp == SPW'(1);
    stat.clear_last = clr_cnt == AW'(NODES - 1);
    stat.out_busy   = out_valid && !out_ready;
  end

endmodule

### hw/rtl/rectangle_union_area_sweep_top.sv
// Union area of rectangles by a sweep over x with a segment tree over y.
// Input channel ev: one open or close event per beat, x nondecreasing.
// Intervals [y_low, y_high) are clipped to Y_CELLS; an empty interval only
// reports the current state. restart clears area and previous x, not the tree.
// Output channel res: one beat per event with the area up to this x and the
// covered y width after the event.
// One event is in work at a time. An empty interval passes from the accept
// through the multiply state straight to the result register. Otherwise the
// update visits each tree node it touches (up to about four per level), with
// the node read, child read and write-back that each node needs, all through
// the single read port of the node memory.
// The next event is accepted in the cycle after the result register loads.
// The result register frees the input side: a new event is accepted while
// a result still waits, and only the next result waits on a stalled receiver.
// After reset all 4 * Y_CELLS entries of the node memory are cleared, one entry
// a cycle, with ev.ready low; area, previous x and the tree start at zero.
module rectangle_union_area_sweep_top #(
  parameter int Y_CELLS = 1024,
  parameter int X_BITS  = 16
) (
  input logic           clk,
  input logic           rst,
  rusa_event_if.sink    ev,
  rusa_result_if.source res
);

  rusa_pkg::dp_cmd_t  cmd;
  rusa_pkg::dp_stat_t stat;

  rusa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ev.valid),
    .in_ready (ev.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rusa_dp #(
    .Y_CELLS (Y_CELLS),
    .X_BITS  (X_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (ev.operation),
    .x_coord       (ev.x_coord),
    .y_low         (ev.y_low),
    .y_high        (ev.y_high),
    .restart       (ev.restart),
    .out_ready     (res.ready),
    .out_valid     (res.valid),
    .area_so_far   (res.area_so_far),
    .covered_width (res.covered_width)
  );

endmodule

### hw/rtl/rusa_checker.sv
`include "rectangle_union_area_sweep_top_assert.svh"

module rusa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           ev_valid,
  input logic                           ev_ready,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [rusa_pkg::AREA_W-1:0]    res_area,
  input logic [rusa_pkg::WIDTH_O_W-1:0] res_width
);

  // A result beat that is not taken stays offered and unchanged.
  `RUSA_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  `RUSA_ASSERT_NEXT(a_res_stable, clk, rst, res_valid && !res_ready, $stable(res_area) && $stable(res_width))

  // The block works on one event at a time.
  `RUSA_ASSERT_NEXT(a_one_event, clk, rst, ev_valid && ev_ready, !ev_ready)

  // The memory clearing pass starts with reset, so nothing is taken or offered.
  `RUSA_ASSERT_RESET(a_reset_quiet, clk, rst, !ev_ready && !res_valid)

endmodule

bind rectangle_union_area_sweep_top rusa_checker u_rusa_checker (
  .clk       (clk),
  .rst       (rst),
  .ev_valid  (ev.valid),
  .ev_ready  (ev.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_area  (res.area_so_far),
  .res_width (res.covered_width)
);
